@@ rtl/core/pmm_pkg.sv @@
package pmm_pkg;

  localparam int PMM_PAGE_COUNT = 16;

  localparam int OP_W     = 3;
  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 8;
  localparam int KIND_W   = 3;
  localparam int OFFS_W   = 12;
  localparam int MODE_W   = 4;

  localparam logic [OP_W-1:0] OP_MEM_RD  = 3'd0;
  localparam logic [OP_W-1:0] OP_MEM_WR  = 3'd1;
  localparam logic [OP_W-1:0] OP_PAGE_WR = 3'd2;
  localparam logic [OP_W-1:0] OP_PAGE_RD = 3'd3;
  localparam logic [OP_W-1:0] OP_MODE_WR = 3'd4;

  localparam logic [KIND_W-1:0] KIND_NONE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RAM_RD = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ROM_RD = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RAM_WR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REG    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_ACK    = 3'd5;

  localparam logic [DATA_W-1:0] PAGE_RESET = 8'hFF;

  localparam logic [DATA_W-1:0] CODE_PLANE_R0 = 8'hE6;
  localparam logic [DATA_W-1:0] CODE_PLANE_R1 = 8'hE7;
  localparam logic [DATA_W-1:0] CODE_PLANE_G0 = 8'hEA;
  localparam logic [DATA_W-1:0] CODE_PLANE_G1 = 8'hEB;
  localparam logic [DATA_W-1:0] CODE_PLANE_B0 = 8'hEE;
  localparam logic [DATA_W-1:0] CODE_PLANE_B1 = 8'hEF;

  localparam logic [3:0] CODE_RAM_HI = 4'hE;
  localparam logic [4:0] CODE_ROM_HI = 5'b11111;

  localparam logic [ADDR_W-1:0] BASE_RED   = 16'h6000;
  localparam logic [ADDR_W-1:0] BASE_GREEN = 16'hA000;
  localparam logic [ADDR_W-1:0] BASE_BLUE  = 16'hE000;
  localparam logic [ADDR_W-1:0] HALF_OFFS  = 16'h1000;

  localparam logic [1:0] BEAT_LAST = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] target_address;
    logic [DATA_W-1:0] out_byte;
    logic              last;
  } pmm_result_t;

  typedef struct packed {
    logic              page_we;
    logic              video_we;
    logic [DATA_W-1:0] data;
  } pmm_wr_t;

  function automatic logic [ADDR_W-1:0] plane_base(input logic [1:0] plane);
    logic [ADDR_W-1:0] b;
    unique case (plane)
      2'd0:    b = BASE_RED;
      2'd1:    b = BASE_GREEN;
      default: b = BASE_BLUE;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/core/pmm_req_if.sv @@
interface pmm_req_if import pmm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] wdata;

  modport source(output valid, output operation, output address, output wdata, input ready);
  modport sink(input valid, input operation, input address, input wdata, output ready);
endinterface

@@ rtl/core/pmm_rsp_if.sv @@
interface pmm_rsp_if import pmm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ADDR_W-1:0] target_address;
  logic [DATA_W-1:0] out_byte;
  logic              last;

  modport source(output valid, output kind, output target_address, output out_byte,
                 output last, input ready);
  modport sink(input valid, input kind, input target_address, input out_byte,
               input last, output ready);
endinterface

@@ rtl/core/pmm_regs.sv @@
module pmm_regs import pmm_pkg::*; #(
  parameter int PAGE_COUNT = PMM_PAGE_COUNT,
  localparam int SEL_W = $clog2(PAGE_COUNT)
) (
  input  logic              clk,
  input  logic              rst,
  input  pmm_wr_t           wr,
  input  logic [SEL_W-1:0]  wr_sel,
  input  logic [SEL_W-1:0]  rd_sel,
  output logic [DATA_W-1:0] rd_code,
  output logic [MODE_W-1:0] video_mode
);

  logic [DATA_W-1:0] page_map [PAGE_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PAGE_COUNT; i++) begin
        page_map[i] <= PAGE_RESET;
      end
      video_mode <= '0;
    end else begin
      if (wr.page_we) begin
        page_map[wr_sel] <= wr.data;
      end
      if (wr.video_we) begin
        video_mode <= wr.data[MODE_W-1:0];
      end
    end
  end

  assign rd_code = page_map[rd_sel];

endmodule

@@ rtl/core/pmm_decode.sv @@
module pmm_decode import pmm_pkg::*; (
  input  logic [OP_W-1:0]   op,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] data,
  input  logic [DATA_W-1:0] code,
  input  logic [MODE_W-1:0] video_mode,
  input  logic [1:0]        beat,
  output pmm_result_t       res,
  output pmm_wr_t           wr
);

  logic [3:0]        page;
  logic [OFFS_W-1:0] offs;
  logic              is_ram;
  logic              is_rom;
  logic              is_plane;
  logic              multi;
  logic [1:0]        plane;
  logic [ADDR_W-1:0] plane_addr;
  logic [DATA_W-1:0] plane_byte;

  always_comb begin
    page     = code[3:0];
    offs     = addr[OFFS_W-1:0];
    is_ram   = (code[7:4] == CODE_RAM_HI);
    is_rom   = (code[7:3] == CODE_ROM_HI);
    is_plane = (code == CODE_PLANE_R0) || (code == CODE_PLANE_R1) ||
               (code == CODE_PLANE_G0) || (code == CODE_PLANE_G1) ||
               (code == CODE_PLANE_B0) || (code == CODE_PLANE_B1);
    multi    = video_mode[3];

    // codes 6/7 red, 10/11 green, 14/15 blue: plane is page[3:2] minus one
    if (multi) begin
      plane = beat;
    end else begin
      plane = page[3:2] - 2'd1;
    end
    plane_addr = plane_base(plane) + {{(ADDR_W-OFFS_W){1'b0}}, offs} +
                 (page[0] ? HALF_OFFS : '0);
    plane_byte = (!multi || video_mode[plane]) ? data : '0;

    res = '{kind: KIND_NONE, target_address: '0, out_byte: '0, last: 1'b1};
    wr  = '{page_we: 1'b0, video_we: 1'b0, data: data};

    unique case (op)
      OP_MEM_RD: begin
        if (is_ram) begin
          res.kind           = KIND_RAM_RD;
          res.target_address = {page, offs};
        end else if (is_rom) begin
          res.kind           = KIND_ROM_RD;
          res.target_address = {1'b0, page[2:0], offs};
        end
      end
      OP_MEM_WR: begin
        if (is_ram && is_plane) begin
          res.kind           = KIND_RAM_WR;
          res.target_address = plane_addr;
          res.out_byte       = plane_byte;
          res.last           = !multi || (beat == BEAT_LAST);
        end else if (is_ram) begin
          res.kind           = KIND_RAM_WR;
          res.target_address = {page, offs};
          res.out_byte       = data;
        end
      end
      OP_PAGE_WR: begin
        res.kind   = KIND_ACK;
        wr.page_we = 1'b1;
      end
      OP_PAGE_RD: begin
        res.kind     = KIND_REG;
        res.out_byte = code;
      end
      OP_MODE_WR: begin
        res.kind    = KIND_ACK;
        wr.video_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/paged_memory_mapper_with_plane_writes.sv @@
// channel | dir | transaction
// req     | in  | CPU access: operation, address, wdata
// rsp     | out | memory command: kind, target_address, out_byte, last
//
// Each access passes through the input register; a copy-mode video write
// holds the input register while its three plane writes pass through the
// result register, and the next access is taken only with the last of them.
// Synchronous reset sets every page register to 0xFF and video mode to zero.
// A stalled rsp holds the result register; req is still taken while the input
// register is empty or its last result moves to the result register in that cycle.
module paged_memory_mapper_with_plane_writes import pmm_pkg::*; #(
  parameter int PAGE_COUNT = PMM_PAGE_COUNT
) (
  input logic     clk,
  input logic     rst,
  pmm_req_if.sink   req,
  pmm_rsp_if.source rsp
);

  localparam int SEL_W = $clog2(PAGE_COUNT);

  logic              s_valid;
  logic [OP_W-1:0]   s_op;
  logic [ADDR_W-1:0] s_addr;
  logic [DATA_W-1:0] s_data;
  logic [1:0]        beat;

  logic              o_valid;
  pmm_result_t       o_res;

  logic [DATA_W-1:0] code;
  logic [MODE_W-1:0] video_mode;
  logic [SEL_W-1:0]  rd_sel;
  pmm_result_t       res;
  pmm_wr_t           dec_wr;
  pmm_wr_t           wr_cmd;

  logic load;
  logic done;
  logic accept;

  assign load   = s_valid && (!o_valid || rsp.ready);
  assign done   = load && res.last;
  assign accept = req.valid && req.ready;

  assign req.ready = !s_valid || done;

  // page register operations select by the low address bits, memory ops by window
  assign rd_sel = (s_op == OP_PAGE_RD) ? s_addr[SEL_W-1:0] : s_addr[ADDR_W-1 -: SEL_W];

  always_comb begin
    wr_cmd          = dec_wr;
    wr_cmd.page_we  = done && dec_wr.page_we;
    wr_cmd.video_we = done && dec_wr.video_we;
  end

  pmm_regs #(
    .PAGE_COUNT(PAGE_COUNT)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr_cmd),
    .wr_sel    (s_addr[SEL_W-1:0]),
    .rd_sel    (rd_sel),
    .rd_code   (code),
    .video_mode(video_mode)
  );

  pmm_decode u_decode (
    .op        (s_op),
    .addr      (s_addr),
    .data      (s_data),
    .code      (code),
    .video_mode(video_mode),
    .beat      (beat),
    .res       (res),
    .wr        (dec_wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      beat    <= '0;
      o_valid <= 1'b0;
    end else begin
      if (accept) begin
        s_valid <= 1'b1;
      end else if (done) begin
        s_valid <= 1'b0;
      end
      if (done) begin
        beat <= '0;
      end else if (load) begin
        beat <= beat + 2'd1;
      end
      if (load) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_op   <= req.operation;
      s_addr <= req.address;
      s_data <= req.wdata;
    end
    if (load) begin
      o_res <= res;
    end
  end

  assign rsp.valid          = o_valid;
  assign rsp.kind           = o_res.kind;
  assign rsp.target_address = o_res.target_address;
  assign rsp.out_byte       = o_res.out_byte;
  assign rsp.last           = o_res.last;

  a_beat_range: assert property (@(posedge clk) disable iff (rst) beat != 2'd3)
    else $error("beat counter out of range");

  a_idle_beat: assert property (@(posedge clk) disable iff (rst) !s_valid |-> beat == 2'd0)
    else $error("beat counter nonzero with empty input register");

  a_multi_hold: assert property (@(posedge clk) disable iff (rst)
    (load && !res.last) |=> (s_valid && beat != 2'd0))
    else $error("copy write dropped before its last plane");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    done |=> (beat == 2'd0 && o_valid))
    else $error("finished item left beat counter or result register wrong");

endmodule
